>>> sv/audio_onset_slicer_top_assert.svh
// ----------------------------------------------------------------------------
// audio_onset_slicer_top_assert: assertion macros
// Shorthand for clocked implication checks with a reset disable.
// ----------------------------------------------------------------------------
`ifndef AUDIO_ONSET_SLICER_TOP_ASSERT_SVH
`define AUDIO_ONSET_SLICER_TOP_ASSERT_SVH

// same-cycle implication
`define AOS_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AOS_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/aos_pkg.sv
// ----------------------------------------------------------------------------
// aos_pkg: shared types and constants
// Widths, register indexes, reset values and stage payloads of the slicer.
// ----------------------------------------------------------------------------
package aos_pkg;

   localparam int FRAME_BITS     = 32;
   localparam int COEF_BITS      = 16;
   localparam int COEF_REG_BITS  = 16;
   localparam int SAMPLE_BITS    = 16;
   localparam int MAG_BITS       = 16;
   localparam int ENV_BITS       = 32;
   localparam int FIELD_BITS     = 32;
   localparam int CSR_INDEX_BITS = 4;
   // frame arithmetic width, at least as wide as the 32-bit registers
   localparam int CALC_BITS      = (FRAME_BITS > FIELD_BITS) ? FRAME_BITS : FIELD_BITS;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ENV_COEF     = CSR_INDEX_BITS'(0),
      CSR_LEVEL_THRESH = CSR_INDEX_BITS'(1),
      CSR_DELTA_THRESH = CSR_INDEX_BITS'(2),
      CSR_REFRACTORY   = CSR_INDEX_BITS'(3),
      CSR_PRE_FRAMES   = CSR_INDEX_BITS'(4),
      CSR_SLICE_FRAMES = CSR_INDEX_BITS'(5),
      CSR_MIN_FRAMES   = CSR_INDEX_BITS'(6),
      CSR_TOTAL_FRAMES = CSR_INDEX_BITS'(7)
   } csr_reg_type;

   localparam logic [COEF_BITS-1:0]  ENV_COEF_RST   = COEF_BITS'(65400);
   localparam logic [COEF_BITS:0]    COEF_ONE       = {1'b1, {COEF_BITS{1'b0}}};
   localparam logic [COEF_BITS:0]    COEF_B_RST     = COEF_ONE - {1'b0, ENV_COEF_RST};
   localparam logic [FIELD_BITS-1:0] LEVEL_RST      = 32'd10737418;
   localparam logic [FIELD_BITS-1:0] DELTA_RST      = 32'd536871;
   localparam logic [FIELD_BITS-1:0] REFRACTORY_RST = 32'd5760;
   localparam logic [FIELD_BITS-1:0] PRE_RST        = 32'd0;
   localparam logic [FIELD_BITS-1:0] SLICE_RST      = 32'd48000;
   localparam logic [FIELD_BITS-1:0] MIN_RST        = 32'd0;
   localparam logic [FIELD_BITS-1:0] TOTAL_RST      = 32'hFFFF_FFFF;
   localparam logic [FIELD_BITS-1:0] DELTA_MAX      = 32'h7FFF_FFFF;

   typedef struct packed {
      logic [MAG_BITS-1:0] mag;
      logic                sob;
   } mag_item_type;

   typedef struct packed {
      logic [ENV_BITS-1:0]   env;
      logic [FIELD_BITS-1:0] delta;
      logic [FRAME_BITS-1:0] frame;
      logic                  sob;
   } env_item_type;

   typedef struct packed {
      logic [FRAME_BITS-1:0] frame;
      logic [ENV_BITS-1:0]   env;
      logic [FIELD_BITS-1:0] delta;
   } onset_item_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] level;
      logic [FIELD_BITS-1:0] delta;
      logic [FIELD_BITS-1:0] refractory;
   } detect_cfg_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] pre;
      logic [FIELD_BITS-1:0] slice;
      logic [FIELD_BITS-1:0] min;
      logic [FIELD_BITS-1:0] total;
   } slice_cfg_type;

   typedef struct packed {
      logic s4;
      logic s5;
      logic out;
   } slice_adv_type;

endpackage

>>> sv/audio_onset_slicer_top.sv
// ----------------------------------------------------------------------------
// audio_onset_slicer_top: envelope-follower onset detector with slicing
// Stereo frames in, one slice descriptor out per reported onset.
// ----------------------------------------------------------------------------
//
//   channel   | handshake               | payload
//   ----------+-------------------------+---------------------------------------
//   req_      | req_valid / req_stall   | left, right sample, start_of_buffer
//   rsp_      | rsp_valid / rsp_stall   | onset frame, slice start, length,
//             |                         | envelope, delta
//   csr_      | csr_valid / csr_ready   | csr_index, csr_wdata
//
// one frame per clock sustained while rsp_stall is low; a reported onset moves
// through s1 to s5 into the result register. the rate is set by the envelope
// feedback loop, one pass through the coefficient multiplier per frame.
// reset is synchronous and clears the envelope, frame counter, onset history,
// stage valids and loads the register defaults.
// rsp_stall holds the result register; the stages behind it keep filling and
// non-onset frames drop out, so req_stall rises only once s1 to s5 are full.
//
module audio_onset_slicer_top (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [aos_pkg::SAMPLE_BITS-1:0] req_left_sample,
   input  logic signed [aos_pkg::SAMPLE_BITS-1:0] req_right_sample,
   input  logic                                   req_start_of_buffer,

   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic        [aos_pkg::FIELD_BITS-1:0]  rsp_onset_frame,
   output logic        [aos_pkg::FIELD_BITS-1:0]  rsp_slice_start,
   output logic        [aos_pkg::FIELD_BITS-1:0]  rsp_slice_length,
   output logic        [aos_pkg::FIELD_BITS-1:0]  rsp_onset_envelope,
   output logic signed [aos_pkg::FIELD_BITS-1:0]  rsp_onset_delta,

   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [aos_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [aos_pkg::FIELD_BITS-1:0]         csr_wdata
);

   // configuration registers; b = 1 - a is kept instead of a
   logic [aos_pkg::COEF_BITS:0]    coef_b_ff;
   logic [aos_pkg::FIELD_BITS-1:0] level_ff, delta_ff, refractory_ff;
   logic [aos_pkg::FIELD_BITS-1:0] pre_ff, slice_ff, min_ff, total_ff;

   // stage valids
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic out_valid_ff;

   // stage ready chain, a bubble anywhere lets the stages behind it move
   logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy, out_rdy;

   // lane outputs and the merged magnitude
   logic [aos_pkg::MAG_BITS-1:0]   left_mag, right_mag;
   logic [aos_pkg::MAG_BITS:0]     mag_sum;
   aos_pkg::mag_item_type          s1_item_ff, s1_item_in;

   aos_pkg::env_item_type          s2_item;
   aos_pkg::onset_item_type        s3_item;
   aos_pkg::detect_cfg_type        detect_cfg;
   aos_pkg::slice_cfg_type         slice_cfg;
   aos_pkg::slice_adv_type         slice_adv;
   logic                           fire;
   logic                           keep;

   assign csr_ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_b_ff     <= aos_pkg::COEF_B_RST;
         level_ff      <= aos_pkg::LEVEL_RST;
         delta_ff      <= aos_pkg::DELTA_RST;
         refractory_ff <= aos_pkg::REFRACTORY_RST;
         pre_ff        <= aos_pkg::PRE_RST;
         slice_ff      <= aos_pkg::SLICE_RST;
         min_ff        <= aos_pkg::MIN_RST;
         total_ff      <= aos_pkg::TOTAL_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (aos_pkg::csr_reg_type'(csr_index))
            aos_pkg::CSR_ENV_COEF: begin
               coef_b_ff <= aos_pkg::COEF_ONE -
                  {1'b0, aos_pkg::COEF_BITS'(csr_wdata[aos_pkg::COEF_REG_BITS-1:0])};
            end
            aos_pkg::CSR_LEVEL_THRESH: level_ff      <= csr_wdata;
            aos_pkg::CSR_DELTA_THRESH: delta_ff      <= csr_wdata;
            aos_pkg::CSR_REFRACTORY:   refractory_ff <= csr_wdata;
            aos_pkg::CSR_PRE_FRAMES:   pre_ff        <= csr_wdata;
            aos_pkg::CSR_SLICE_FRAMES: slice_ff      <= csr_wdata;
            aos_pkg::CSR_MIN_FRAMES:   min_ff        <= csr_wdata;
            aos_pkg::CSR_TOTAL_FRAMES: total_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign out_rdy   = !out_valid_ff || !rsp_stall;
   assign s5_rdy    = !s5_valid_ff || out_rdy;
   assign s4_rdy    = !s4_valid_ff || s5_rdy;
   assign s3_rdy    = !s3_valid_ff || s4_rdy;
   assign s2_rdy    = !s2_valid_ff || s3_rdy;
   assign s1_rdy    = !s1_valid_ff || s2_rdy;
   assign req_stall = !s1_rdy;

   // non-onset frames drop out after the decision, dropped slices at the end
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_rdy)  s1_valid_ff  <= req_valid;
         if (s2_rdy)  s2_valid_ff  <= s1_valid_ff;
         if (s3_rdy)  s3_valid_ff  <= s2_valid_ff && fire;
         if (s4_rdy)  s4_valid_ff  <= s3_valid_ff;
         if (s5_rdy)  s5_valid_ff  <= s4_valid_ff;
         if (out_rdy) out_valid_ff <= s5_valid_ff && keep;
      end
   end

   // per-channel magnitude lanes
   aos_mag_lane u_lane_left (
      .sample    (req_left_sample),
      .magnitude (left_mag)
   );

   aos_mag_lane u_lane_right (
      .sample    (req_right_sample),
      .magnitude (right_mag)
   );

   // merge: mean of the two magnitudes, truncated
   always_comb begin
      mag_sum        = {1'b0, left_mag} + {1'b0, right_mag};
      s1_item_in.mag = mag_sum[aos_pkg::MAG_BITS:1];
      s1_item_in.sob = req_start_of_buffer;
   end

   always_ff @(posedge clock) begin
      if (req_valid && s1_rdy) begin
         s1_item_ff <= s1_item_in;
      end
   end

   // envelope and frame counter
   aos_follower u_follower (
      .clock    (clock),
      .reset    (reset),
      .advance  (s1_valid_ff && s2_rdy),
      .item_in  (s1_item_ff),
      .coef_b   (coef_b_ff),
      .item_out (s2_item)
   );

   assign detect_cfg.level      = level_ff;
   assign detect_cfg.delta      = delta_ff;
   assign detect_cfg.refractory = refractory_ff;

   // onset decision and history; every frame updates it, firing or not
   aos_detect u_detect (
      .clock    (clock),
      .reset    (reset),
      .advance  (s2_valid_ff && s3_rdy),
      .item_in  (s2_item),
      .cfg      (detect_cfg),
      .fire     (fire),
      .item_out (s3_item)
   );

   assign slice_cfg.pre   = pre_ff;
   assign slice_cfg.slice = slice_ff;
   assign slice_cfg.min   = min_ff;
   assign slice_cfg.total = total_ff;

   assign slice_adv.s4  = s3_valid_ff && s4_rdy;
   assign slice_adv.s5  = s4_valid_ff && s5_rdy;
   assign slice_adv.out = s5_valid_ff && keep && out_rdy;

   // slice bounds and the result register
   aos_slicer u_slicer (
      .clock          (clock),
      .adv            (slice_adv),
      .item_in        (s3_item),
      .cfg            (slice_cfg),
      .keep           (keep),
      .onset_frame    (rsp_onset_frame),
      .slice_start    (rsp_slice_start),
      .slice_length   (rsp_slice_length),
      .onset_envelope (rsp_onset_envelope),
      .onset_delta    (rsp_onset_delta)
   );

   assign rsp_valid = out_valid_ff;

endmodule

>>> sv/aos_mag_lane.sv
// ----------------------------------------------------------------------------
// aos_mag_lane: one channel magnitude lane
// Absolute value of a signed sample, full range kept (-32768 gives 32768).
// ----------------------------------------------------------------------------
module aos_mag_lane (
   input  logic signed [aos_pkg::SAMPLE_BITS-1:0] sample,
   output logic        [aos_pkg::MAG_BITS-1:0]    magnitude
);

   logic [aos_pkg::SAMPLE_BITS-1:0] raw;
   logic [aos_pkg::SAMPLE_BITS-1:0] negated;

   assign raw       = sample;
   assign negated   = ~raw + aos_pkg::SAMPLE_BITS'(1);
   assign magnitude = aos_pkg::MAG_BITS'(raw[aos_pkg::SAMPLE_BITS-1] ? negated : raw);

endmodule

>>> sv/aos_follower.sv
// ----------------------------------------------------------------------------
// aos_follower: envelope follower and frame counter
// One-pole smoothing written as env + b*(target - env), b = 1 - a, rounded,
// plus the saturated frame-to-frame envelope difference.
// ----------------------------------------------------------------------------
module aos_follower (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  aos_pkg::mag_item_type         item_in,
   input  logic [aos_pkg::COEF_BITS:0]   coef_b,
   output aos_pkg::env_item_type         item_out
);

   localparam int PW = aos_pkg::COEF_BITS + aos_pkg::ENV_BITS + 3;
   localparam logic signed [PW-1:0] HALF = PW'(64'd1 << (aos_pkg::COEF_BITS - 1));

   logic [aos_pkg::ENV_BITS-1:0]     env_ff, env_in;
   logic [aos_pkg::FRAME_BITS-1:0]   frame_ff, frame_in;
   aos_pkg::env_item_type            item_ff;

   logic [aos_pkg::ENV_BITS-1:0]     env_old;
   logic [aos_pkg::FRAME_BITS-1:0]   cur;
   logic [aos_pkg::ENV_BITS-1:0]     target;
   logic signed [aos_pkg::ENV_BITS:0] diff;
   logic signed [PW-1:0]             prod;
   logic signed [PW-1:0]             step;
   logic signed [PW-1:0]             env_sum;
   logic signed [aos_pkg::ENV_BITS:0] delta_full;
   logic [aos_pkg::FIELD_BITS-1:0]   delta_sat;

   always_comb begin
      env_old    = item_in.sob ? '0 : env_ff;
      cur        = item_in.sob ? '0 : frame_ff;
      target     = aos_pkg::ENV_BITS'({item_in.mag, 16'b0});
      diff       = $signed({1'b0, target}) - $signed({1'b0, env_old});
      prod       = $signed({1'b0, coef_b}) * diff;
      // floor of the rounded product, arithmetic shift keeps the sign
      step       = (prod + HALF) >>> aos_pkg::COEF_BITS;
      env_sum    = $signed({{(PW - aos_pkg::ENV_BITS){1'b0}}, env_old}) + step;
      env_in     = env_sum[aos_pkg::ENV_BITS-1:0];
      frame_in   = cur + aos_pkg::FRAME_BITS'(1);
      delta_full = $signed({1'b0, env_in}) - $signed({1'b0, env_old});
      // only a full-scale jump from zero overflows the positive range
      if (!delta_full[aos_pkg::ENV_BITS] && delta_full[aos_pkg::FIELD_BITS-1]) begin
         delta_sat = aos_pkg::DELTA_MAX;
      end else begin
         delta_sat = delta_full[aos_pkg::FIELD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff   <= '0;
         frame_ff <= '0;
      end else if (advance) begin
         env_ff   <= env_in;
         frame_ff <= frame_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff.env   <= env_in;
         item_ff.delta <= delta_sat;
         item_ff.frame <= cur;
         item_ff.sob   <= item_in.sob;
      end
   end

   assign item_out = item_ff;

endmodule

>>> sv/aos_detect.sv
// ----------------------------------------------------------------------------
// aos_detect: onset decision
// Refractory, level and rise tests against the last onset frame.
// ----------------------------------------------------------------------------
module aos_detect (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  aos_pkg::env_item_type   item_in,
   input  aos_pkg::detect_cfg_type cfg,
   output logic                    fire,
   output aos_pkg::onset_item_type item_out
);

   logic [aos_pkg::FRAME_BITS-1:0] last_ff, last_in;
   logic                           seen_ff, seen_in;
   aos_pkg::onset_item_type        item_ff;

   logic [aos_pkg::FRAME_BITS-1:0] last_eff;
   logic                           seen_eff;
   logic [aos_pkg::FRAME_BITS-1:0] since;
   logic                           elig;
   logic                           level_ok;
   logic                           rise_ok;

   always_comb begin
      last_eff = item_in.sob ? '0 : last_ff;
      seen_eff = item_in.sob ? 1'b0 : seen_ff;
      // wraps with the frame counter
      since    = item_in.frame - last_eff;
      elig     = !seen_eff ||
                 (aos_pkg::CALC_BITS'(since) >= aos_pkg::CALC_BITS'(cfg.refractory));
      level_ok = item_in.env >= cfg.level;
      rise_ok  = $signed({item_in.delta[aos_pkg::FIELD_BITS-1], item_in.delta}) >=
                 $signed({1'b0, cfg.delta});
      fire     = elig && level_ok && rise_ok;
      last_in  = fire ? item_in.frame : last_eff;
      seen_in  = fire || seen_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
         seen_ff <= 1'b0;
      end else if (advance) begin
         last_ff <= last_in;
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff.frame <= item_in.frame;
         item_ff.env   <= item_in.env;
         item_ff.delta <= item_in.delta;
      end
   end

   assign item_out = item_ff;

endmodule

>>> sv/aos_slicer.sv
// ----------------------------------------------------------------------------
// aos_slicer: slice bounds and result register
// Start with preroll, room to buffer end, length clamp and minimum filter.
// ----------------------------------------------------------------------------
module aos_slicer (
   input  logic                                  clock,
   input  aos_pkg::slice_adv_type                adv,
   input  aos_pkg::onset_item_type               item_in,
   input  aos_pkg::slice_cfg_type                cfg,
   output logic                                  keep,
   output logic        [aos_pkg::FIELD_BITS-1:0] onset_frame,
   output logic        [aos_pkg::FIELD_BITS-1:0] slice_start,
   output logic        [aos_pkg::FIELD_BITS-1:0] slice_length,
   output logic        [aos_pkg::FIELD_BITS-1:0] onset_envelope,
   output logic signed [aos_pkg::FIELD_BITS-1:0] onset_delta
);

   aos_pkg::onset_item_type         s4_item_ff, s5_item_ff;
   logic [aos_pkg::CALC_BITS-1:0]   s4_start_ff, s5_start_ff;
   logic [aos_pkg::FIELD_BITS-1:0]  s5_room_ff;

   logic [aos_pkg::CALC_BITS-1:0]   frame_c, pre_c, total_c, start_in;
   logic [aos_pkg::FIELD_BITS-1:0]  room_in, len_in;

   logic [aos_pkg::FIELD_BITS-1:0]  frame_out_ff, start_out_ff, len_out_ff;
   logic [aos_pkg::FIELD_BITS-1:0]  env_out_ff, delta_out_ff;

   always_comb begin
      frame_c  = aos_pkg::CALC_BITS'(item_in.frame);
      pre_c    = aos_pkg::CALC_BITS'(cfg.pre);
      total_c  = aos_pkg::CALC_BITS'(cfg.total);
      start_in = (frame_c > pre_c) ? (frame_c - pre_c) : '0;
      // frames left in the buffer from the slice start
      room_in  = (total_c > s4_start_ff) ?
                 aos_pkg::FIELD_BITS'(total_c - s4_start_ff) : '0;
      len_in   = (s5_room_ff < cfg.slice) ? s5_room_ff : cfg.slice;
      keep     = len_in >= cfg.min;
   end

   always_ff @(posedge clock) begin
      if (adv.s4) begin
         s4_item_ff  <= item_in;
         s4_start_ff <= start_in;
      end
      if (adv.s5) begin
         s5_item_ff  <= s4_item_ff;
         s5_start_ff <= s4_start_ff;
         s5_room_ff  <= room_in;
      end
      if (adv.out) begin
         frame_out_ff <= aos_pkg::FIELD_BITS'(s5_item_ff.frame);
         start_out_ff <= aos_pkg::FIELD_BITS'(s5_start_ff);
         len_out_ff   <= len_in;
         env_out_ff   <= aos_pkg::FIELD_BITS'(s5_item_ff.env);
         delta_out_ff <= s5_item_ff.delta;
      end
   end

   assign onset_frame    = frame_out_ff;
   assign slice_start    = start_out_ff;
   assign slice_length   = len_out_ff;
   assign onset_envelope = env_out_ff;
   assign onset_delta    = $signed(delta_out_ff);

endmodule

>>> sv/aos_checker.sv
// ----------------------------------------------------------------------------
// aos_checker: port-level checks on the slicer
// Result hold under stall and range relations between result fields.
// ----------------------------------------------------------------------------
`include "audio_onset_slicer_top_assert.svh"

module aos_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic        [aos_pkg::FIELD_BITS-1:0] rsp_onset_frame,
   input logic        [aos_pkg::FIELD_BITS-1:0] rsp_slice_start,
   input logic        [aos_pkg::FIELD_BITS-1:0] rsp_slice_length,
   input logic        [aos_pkg::FIELD_BITS-1:0] rsp_onset_envelope,
   input logic signed [aos_pkg::FIELD_BITS-1:0] rsp_onset_delta
);

   // a stalled result stays in place
   `AOS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_onset_frame) && $stable(rsp_slice_length), "stalled result changed")

   // preroll never moves the start past the onset
   `AOS_ASSERT_IMP(a_start_order, clock, reset, rsp_valid, rsp_slice_start <= rsp_onset_frame, "slice start after onset")

   // the rise threshold is unsigned, so a reported rise is never negative
   `AOS_ASSERT_IMP(a_delta_sign, clock, reset, rsp_valid, !rsp_onset_delta[aos_pkg::FIELD_BITS-1], "negative onset delta")

   // envelope stays within Q1.31 full scale
   `AOS_ASSERT_IMP(a_env_range, clock, reset, rsp_valid, rsp_onset_envelope <= 32'h8000_0000, "envelope above full scale")

endmodule

bind audio_onset_slicer_top aos_checker u_aos_checker (.*);

>>> tb/aos_slice_checker.sv
// ----------------------------------------------------------------------------
// aos_slice_checker: slice descriptor scoreboard
// Watches the frame, slice and register channels of the slicer, follows the
// envelope of every frame transfer and compares each slice descriptor with
// the oldest one expected.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aos_slice_checker
   import aos_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic [SAMPLE_BITS-1:0]    req_left_sample,
   input  logic [SAMPLE_BITS-1:0]    req_right_sample,
   input  logic                      req_start_of_buffer,

   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [FIELD_BITS-1:0]     rsp_onset_frame,
   input  logic [FIELD_BITS-1:0]     rsp_slice_start,
   input  logic [FIELD_BITS-1:0]     rsp_slice_length,
   input  logic [FIELD_BITS-1:0]     rsp_onset_envelope,
   input  logic [FIELD_BITS-1:0]     rsp_onset_delta,

   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [FIELD_BITS-1:0]     csr_wdata,

   output int                        fail_count,
   output int                        pending,
   output int                        slices_seen
);

   typedef struct packed {
      logic [FIELD_BITS-1:0] frame;
      logic [FIELD_BITS-1:0] start;
      logic [FIELD_BITS-1:0] length;
      logic [FIELD_BITS-1:0] envelope;
      logic [FIELD_BITS-1:0] delta;
   } slice_rec_t;

   logic [COEF_REG_BITS-1:0] cfg_coef;
   logic [FIELD_BITS-1:0]    cfg_level;
   logic [FIELD_BITS-1:0]    cfg_delta;
   logic [FIELD_BITS-1:0]    cfg_refractory;
   logic [FIELD_BITS-1:0]    cfg_pre;
   logic [FIELD_BITS-1:0]    cfg_span;
   logic [FIELD_BITS-1:0]    cfg_min;
   logic [FIELD_BITS-1:0]    cfg_total;

   longint unsigned          env_level;
   longint unsigned          env_prev;
   logic [FRAME_BITS-1:0]    frame_idx;
   logic [FRAME_BITS-1:0]    last_onset;
   logic                     onset_seen;

   slice_rec_t               expected_slices[$];

   task automatic flag_error(input string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [FIELD_BITS-1:0] got,
                              input logic [FIELD_BITS-1:0] want);
      if (got !== want) begin
         flag_error($sformatf("%s got 0x%08h want 0x%08h", name, got, want));
      end
   endtask

   task automatic clear_follower();
      env_level  = 0;
      env_prev   = 0;
      frame_idx  = '0;
      last_onset = '0;
      onset_seen = 1'b0;
   endtask

   function automatic longint unsigned magnitude(input logic [SAMPLE_BITS-1:0] s);
      return s[SAMPLE_BITS-1] ? (64'd1 << SAMPLE_BITS) - s : 64'(s);
   endfunction

   // one frame through the follower and onset test
   task automatic follow_frame(input logic [SAMPLE_BITS-1:0] left,
                               input logic [SAMPLE_BITS-1:0] right, input logic sob);
      longint unsigned       coef;
      longint unsigned       mag;
      longint unsigned       acc;
      longint unsigned       start;
      longint unsigned       stop;
      longint unsigned       slice_len;
      longint                rise;
      logic [FRAME_BITS-1:0] since;
      slice_rec_t            rec;
      if (sob) begin
         clear_follower();
      end
      mag       = (magnitude(left) + magnitude(right)) >> 1;
      coef      = cfg_coef & ((64'd1 << COEF_BITS) - 1);
      acc       = coef * env_level + ((64'd1 << COEF_BITS) - coef) * (mag << 16)
                + (64'd1 << (COEF_BITS - 1));
      env_level = acc >> COEF_BITS;
      rise      = longint'(env_level) - longint'(env_prev);
      if (rise > 64'sd2147483647) begin
         rise = 64'sd2147483647;
      end
      env_prev  = env_level;
      since     = frame_idx - last_onset;
      if ((!onset_seen || since >= cfg_refractory) && env_level >= cfg_level
          && rise >= longint'(cfg_delta)) begin
         start = (frame_idx > cfg_pre) ? frame_idx - cfg_pre : 64'd0;
         stop  = start + cfg_span;
         if (stop > cfg_total) begin
            stop = cfg_total;
         end
         slice_len  = (stop > start) ? stop - start : 64'd0;
         last_onset = frame_idx;
         onset_seen = 1'b1;
         // short slices are dropped but still restart the refractory window
         if (slice_len >= cfg_min) begin
            rec.frame    = FIELD_BITS'(frame_idx);
            rec.start    = FIELD_BITS'(start);
            rec.length   = FIELD_BITS'(slice_len);
            rec.envelope = FIELD_BITS'(env_level);
            rec.delta    = FIELD_BITS'(rise);
            expected_slices.push_back(rec);
         end
      end
      frame_idx = frame_idx + 1'b1;
   endtask

   always @(posedge clock) begin
      slice_rec_t want;
      if (reset) begin
         cfg_coef       = ENV_COEF_RST;
         cfg_level      = LEVEL_RST;
         cfg_delta      = DELTA_RST;
         cfg_refractory = REFRACTORY_RST;
         cfg_pre        = PRE_RST;
         cfg_span       = SLICE_RST;
         cfg_min        = MIN_RST;
         cfg_total      = TOTAL_RST;
         clear_follower();
         expected_slices.delete();
         fail_count  = 0;
         slices_seen = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ENV_COEF:     cfg_coef       = csr_wdata[COEF_REG_BITS-1:0];
               CSR_LEVEL_THRESH: cfg_level      = csr_wdata;
               CSR_DELTA_THRESH: cfg_delta      = csr_wdata;
               CSR_REFRACTORY:   cfg_refractory = csr_wdata;
               CSR_PRE_FRAMES:   cfg_pre        = csr_wdata;
               CSR_SLICE_FRAMES: cfg_span       = csr_wdata;
               CSR_MIN_FRAMES:   cfg_min        = csr_wdata;
               CSR_TOTAL_FRAMES: cfg_total      = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            follow_frame(req_left_sample, req_right_sample, req_start_of_buffer);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_slices.size() == 0) begin
               flag_error($sformatf("slice at frame %0d with none expected", rsp_onset_frame));
            end else begin
               want = expected_slices.pop_front();
               slices_seen++;
               check_field("onset_frame", rsp_onset_frame, want.frame);
               check_field("slice_start", rsp_slice_start, want.start);
               check_field("slice_length", rsp_slice_length, want.length);
               check_field("onset_envelope", rsp_onset_envelope, want.envelope);
               check_field("onset_delta", rsp_onset_delta, want.delta);
            end
         end
      end
      pending = expected_slices.size();
   end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: onset slicer testbench
// Drives stereo frames and register writes into the slicer, throttles both
// channels at random and leaves checking to the slice scoreboard and the bound checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import aos_pkg::*;

   // frames to send in all, and slices wanted before the random part stops
   localparam int TARGET_FRAMES = 1175;
   localparam int MIN_SLICES    = 48;
   // idle margin after the last expected slice, before touching registers
   localparam int SETTLE_CYCLES = 12;
   // long receiver hold that backs the pipeline up into req_stall
   localparam int LONG_HOLD     = 300;
   localparam int CYCLE_LIMIT   = 600000;

   logic                          clock;
   logic                          reset;

   logic                          req_valid;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_left_sample;
   logic signed [SAMPLE_BITS-1:0] req_right_sample;
   logic                          req_start_of_buffer;

   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [FIELD_BITS-1:0]         rsp_onset_frame;
   logic [FIELD_BITS-1:0]         rsp_slice_start;
   logic [FIELD_BITS-1:0]         rsp_slice_length;
   logic [FIELD_BITS-1:0]         rsp_onset_envelope;
   logic signed [FIELD_BITS-1:0]  rsp_onset_delta;

   logic                          csr_valid;
   logic                          csr_ready;
   logic [CSR_INDEX_BITS-1:0]     csr_index;
   logic [FIELD_BITS-1:0]         csr_wdata;

   int                            fail_count;
   int                            pending;
   int                            slices_seen;
   int                            frames_sent = 0;
   int                            cycle_count = 0;

   // throttle-free stretches on either side
   bit                            req_free = 1'b0;
   bit                            rsp_free = 1'b0;
   // asks the receiver process for one long hold
   logic                          hold_req = 1'b0;

   audio_onset_slicer_top u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_left_sample     (req_left_sample),
      .req_right_sample    (req_right_sample),
      .req_start_of_buffer (req_start_of_buffer),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_onset_frame     (rsp_onset_frame),
      .rsp_slice_start     (rsp_slice_start),
      .rsp_slice_length    (rsp_slice_length),
      .rsp_onset_envelope  (rsp_onset_envelope),
      .rsp_onset_delta     (rsp_onset_delta),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // scoreboard sits beside the block and only watches
   aos_slice_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_left_sample     (req_left_sample),
      .req_right_sample    (req_right_sample),
      .req_start_of_buffer (req_start_of_buffer),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_onset_frame     (rsp_onset_frame),
      .rsp_slice_start     (rsp_slice_start),
      .rsp_slice_length    (rsp_slice_length),
      .rsp_onset_envelope  (rsp_onset_envelope),
      .rsp_onset_delta     (rsp_onset_delta),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .fail_count          (fail_count),
      .pending             (pending),
      .slices_seen         (slices_seen)
   );

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // gap length in cycles: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // random sample within +-amp, clipped to the 16-bit range
   function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int amp);
      int v;
      v = $urandom_range(0, amp);
      if ($urandom_range(0, 1)) return SAMPLE_BITS'(-v);
      return SAMPLE_BITS'(v > 32767 ? 32767 : v);
   endfunction

   // register value: the two extremes now and then, mostly a useful range
   function automatic logic [FIELD_BITS-1:0] pick_reg_value(input logic [FIELD_BITS-1:0] lo,
      input logic [FIELD_BITS-1:0] hi, input logic [FIELD_BITS-1:0] near,
      input logic [FIELD_BITS-1:0] full);
      case ($urandom_range(0, 9))
         0:       return lo;
         1:       return hi;
         2:       return $urandom_range(0, full);
         default: return $urandom_range(0, near);
      endcase
   endfunction

   // one frame transfer, with an optional idle gap in front
   task automatic send_frame(input logic [SAMPLE_BITS-1:0] left,
                             input logic [SAMPLE_BITS-1:0] right, input logic sob);
      int gap;
      gap = req_free ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_left_sample     <= left;
      req_right_sample    <= right;
      req_start_of_buffer <= sob;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      frames_sent++;
      @(negedge clock);
   endtask

   // quiet lead-in then a loud attack, mono or stereo, sometimes a new buffer
   task automatic send_attack();
      int                     quiet;
      int                     loud;
      int                     amp;
      bit                     sob;
      logic [SAMPLE_BITS-1:0] s;
      quiet = $urandom_range(0, 8);
      loud  = $urandom_range(1, 8);
      amp   = ($urandom_range(0, 3) == 0) ? 32768 : $urandom_range(256, 32768);
      sob   = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < quiet + loud; i++) begin
         s = pick_sample(i < quiet ? 64 : amp);
         send_frame(s, ($urandom_range(0, 2) == 0) ? pick_sample(i < quiet ? 64 : amp) : s,
                    sob && i == 0);
      end
   endtask

   // register transfer; valid stays up for a following write
   task automatic write_reg(input csr_reg_type idx, input logic [FIELD_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic load_setting(input logic [FIELD_BITS-1:0] coef, level, delta, refr,
                               pre, span, min_len, total);
      write_reg(CSR_ENV_COEF, coef);
      write_reg(CSR_LEVEL_THRESH, level);
      write_reg(CSR_DELTA_THRESH, delta);
      write_reg(CSR_REFRACTORY, refr);
      write_reg(CSR_PRE_FRAMES, pre);
      write_reg(CSR_SLICE_FRAMES, span);
      write_reg(CSR_MIN_FRAMES, min_len);
      write_reg(CSR_TOTAL_FRAMES, total);
      csr_valid <= 1'b0;
   endtask

   // sender pauses until every expected slice is out, then lets the pipe empty
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // receiver side: random stall runs, plus the long hold on request
   initial begin : rsp_side
      int n;
      rsp_stall <= 1'b0;
      @(negedge clock);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
         end else begin
            n = rsp_free ? 0 : pick_gap();
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(negedge clock);
            end
            rsp_stall <= 1'b0;
            @(negedge clock);
         end
      end
   end

   // watchdog on a hung handshake
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL audio_onset_slicer_top");
      $finish;
   end

   initial begin : stimulus
      int quota;
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_left_sample     <= '0;
      req_right_sample    <= '0;
      req_start_of_buffer <= 1'b0;
      csr_valid           <= 1'b0;
      csr_index           <= CSR_ENV_COEF;
      csr_wdata           <= '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // reset defaults: slow follower, one onset once the envelope clears level
      send_frame(16'h7FFF, 16'h8000, 1'b0);
      send_frame(16'h8000, 16'h7FFF, 1'b0);
      send_frame(16'h8000, 16'h8000, 1'b0);
      send_frame(16'h0000, 16'h0000, 1'b0);

      // instant follower, short refractory and preroll
      wait_idle();
      load_setting(32'd0, 32'd1, 32'd1, 32'd3, 32'd2, 32'd10, 32'd0, 32'hFFFF_FFFF);
      send_frame(16'h0000, 16'h0000, 1'b1);   // new buffer
      send_frame(16'h7FFF, 16'h7FFF, 1'b0);   // first onset, start clamps at 0
      send_frame(16'h8000, 16'h8000, 1'b0);   // still inside refractory window
      send_frame(16'h0000, 16'h0000, 1'b0);
      send_frame(16'h0000, 16'h0000, 1'b0);
      send_frame(16'h8000, 16'h8000, 1'b0);   // full-scale jump, delta saturates
      send_frame(16'h0001, 16'h0000, 1'b0);   // magnitude truncates to 0
      send_frame(16'h0001, 16'h0001, 1'b0);
      send_frame(16'hFFFF, 16'h0001, 1'b0);   // flat envelope, delta below threshold
      send_frame(16'h0064, 16'hFED4, 1'b0);

      // slowest follower, zero-length buffer: slice lies past the buffer end
      wait_idle();
      load_setting(32'd65535, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'd0, 32'd0);
      send_frame(16'h8000, 16'h8000, 1'b1);
      send_frame(16'h0005, 16'h0005, 1'b0);   // refractory never expires
      send_frame(16'h0007, 16'hFFF9, 1'b1);   // new buffer re-arms the first onset

      // short buffer with a minimum length: late slices are dropped
      wait_idle();
      load_setting(32'd32768, 32'd0, 32'd0, 32'd2, 32'd0, 32'd5, 32'd3, 32'd10);
      send_frame(16'h03E8, 16'h03E8, 1'b1);
      repeat (9) send_frame(16'h03E8, 16'h03E8, 1'b0);

      // pressure: a slice every frame while the receiver holds off
      wait_idle();
      load_setting(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd16, 32'd0, 32'hFFFF_FFFF);
      req_free = 1'b1;
      hold_req = 1'b1;
      repeat (40) send_frame(16'd20000, 16'd20000, 1'b0);
      req_free = 1'b0;

      // random settings, each phase a run of attacks with some noise mixed in
      while (frames_sent < TARGET_FRAMES || slices_seen < MIN_SLICES) begin
         wait_idle();
         load_setting(pick_reg_value(32'd0, 32'd65535, 32'd16384, 32'd65535),
                      pick_reg_value(32'd0, 32'h8000_0000, 32'h1000_0000, 32'h8000_0000),
                      pick_reg_value(32'd0, 32'h8000_0000, 32'h0100_0000, 32'h8000_0000),
                      pick_reg_value(32'd0, 32'hFFFF_FFFF, 32'd24, 32'hFFFF_FFFF),
                      pick_reg_value(32'd0, 32'hFFFF_FFFF, 32'd40, 32'hFFFF_FFFF),
                      pick_reg_value(32'd0, 32'hFFFF_FFFF, 32'd200, 32'hFFFF_FFFF),
                      pick_reg_value(32'd0, 32'hFFFF_FFFF, 32'd60, 32'hFFFF_FFFF),
                      pick_reg_value(32'hFFFF_FFFF, 32'd0, 32'd2000, 32'hFFFF_FFFF));
         req_free = ($urandom_range(0, 4) == 0);
         rsp_free = ($urandom_range(0, 4) == 0);
         quota    = frames_sent + $urandom_range(40, 120);
         while (frames_sent < quota) begin
            if ($urandom_range(0, 4) == 0) begin
               send_frame(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
                          $urandom_range(0, 19) == 0);
            end else begin
               send_attack();
            end
         end
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("PASS audio_onset_slicer_top");
      end else begin
         $display("FAIL audio_onset_slicer_top");
      end
      $finish;
   end

endmodule
